>>> src/chp_pkg.sv
// ----------------------------------------------------------------------------
// Container header parser package
// Shared widths, status codes, register indexes and phase type.
// ----------------------------------------------------------------------------
package chp_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned LenW      = 32;
    localparam int unsigned PlaceW    = 24;
    localparam int unsigned StatusW   = 2;
    localparam int unsigned CfgAddrW  = 2;
    localparam int unsigned EntryIdxW = 3;

    // s_tdata: data_byte, container_length
    localparam int unsigned SDataW = 40;
    // m_tdata: status, four place fields, zero padded to whole bytes
    localparam int unsigned MFieldW = StatusW + 4 * PlaceW;
    localparam int unsigned MDataW  = ((MFieldW + 7) / 8) * 8;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BOUNDS    = 2'd2,
        ST_MISSING   = 2'd3
    } status_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_TYPE_CODE  = 2'd0,
        CFG_BINARY_ID  = 2'd1,
        CFG_STRING_ID  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    // byte positions within an 8-byte entry
    localparam logic [EntryIdxW-1:0] POS_TYPE = 3'd0;
    localparam logic [EntryIdxW-1:0] POS_ID   = 3'd1;
    localparam logic [EntryIdxW-1:0] POS_OFS0 = 3'd2;
    localparam logic [EntryIdxW-1:0] POS_OFS1 = 3'd3;
    localparam logic [EntryIdxW-1:0] POS_OFS2 = 3'd4;
    localparam logic [EntryIdxW-1:0] POS_LAST = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ENTRIES = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

endpackage

>>> src/container_header_parser.sv
// ----------------------------------------------------------------------------
// Container header parser
// Walks the header of a binary container and reports repository places.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one header byte per word. s_tuser high marks the
//   count byte of a new container; container_length is sampled with it.
//   A start word aborts whatever container was in progress.
//   Output stream (m_*): one word per container carrying status and the
//   offset/length of the binary and string repositories (zero where not
//   recorded, all zero for status short or out of bounds).
//   Config port: cfg_wr_en/cfg_addr/cfg_wr_data, write only, index 0 type
//   code, 1 binary id, 2 string id. Write only while idle.
// Result: the word is registered, valid in the cycle after the input word that
//   completes it (a start word, or the last byte of an out-of-bounds or last entry).
// Throughput: one input word per cycle while s_tready is high; the whole
//   per-byte update, including the 25-bit bounds add and compare, sits
//   between the input handshake and the state and output registers.
// Stall: the output register holds a result until taken; s_tready stays
//   high while the output is empty or being drained in the same cycle.
// Reset: aresetn synchronous active low; parser returns to waiting for a
//   start word, output empties, registers return to 0 / 0 / 1.
// ----------------------------------------------------------------------------
module container_header_parser
    import chp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CfgAddrW-1:0]   cfg_addr,
    input  logic [ByteW-1:0]      cfg_wr_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SDataW-1:0]     s_tdata,   // [7:0] data_byte, [39:8] container_length
    input  logic                  s_tuser,   // [0] start_req
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [MDataW-1:0]     m_tdata    // [1:0] status, [25:2] binary_offset,
                                             // [49:26] binary_length,
                                             // [73:50] string_offset,
                                             // [97:74] string_length, rest zero
);

    // config registers
    logic [ByteW-1:0] type_code_reg;
    logic [ByteW-1:0] binary_id_reg;
    logic [ByteW-1:0] string_id_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [ByteW-1:0]       left_reg, left_next;
    logic [EntryIdxW-1:0]   pos_reg, pos_next;
    logic [LenW-1:0]        total_reg, total_next;
    logic [ByteW-1:0]       etype_reg, etype_next;
    logic [ByteW-1:0]       eid_reg, eid_next;
    logic [PlaceW-1:0]      eofs_reg, eofs_next;
    logic [PlaceW-1:0]      esize_reg, esize_next;
    logic                   bseen_reg, bseen_next;
    logic                   sseen_reg, sseen_next;
    logic [2*PlaceW-1:0]    bplace_reg, bplace_next;
    logic [2*PlaceW-1:0]    splace_reg, splace_next;

    // output register
    logic                   m_valid_reg;
    logic [MDataW-1:0]      m_data_reg, m_data_next;

    logic                   accept;
    logic                   emit;
    status_t                status;
    logic [ByteW-1:0]       din;
    logic [LenW-1:0]        din_len;
    logic [ByteW+EntryIdxW:0] hdr_need;   // 1 + 8 * count
    logic [PlaceW:0]        end_sum;      // offset + length of entry
    logic                   places;

    assign din      = s_tdata[ByteW-1:0];
    assign din_len  = s_tdata[ByteW +: LenW];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign hdr_need = {1'b0, din, {EntryIdxW{1'b0}}} + {{(ByteW+EntryIdxW){1'b0}}, 1'b1};
    // last size byte arrives with the closing word
    assign end_sum  = {1'b0, eofs_reg} + {1'b0, esize_reg[PlaceW-ByteW-1:0], din};

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        etype_next  = etype_reg;
        eid_next    = eid_reg;
        eofs_next   = eofs_reg;
        esize_next  = esize_reg;
        bseen_next  = bseen_reg;
        sseen_next  = sseen_reg;
        bplace_next = bplace_reg;
        splace_next = splace_reg;
        emit        = 1'b0;
        status      = ST_OK;

        if (accept && s_tuser) begin
            total_next = din_len;
            left_next  = din;
            pos_next   = '0;
            bseen_next = 1'b0;
            sseen_next = 1'b0;
            if (din_len == '0 ||
                {{(LenW-ByteW-EntryIdxW-1){1'b0}}, hdr_need} > din_len) begin
                emit   = 1'b1;
                status = ST_SHORT;
            end else if (din == '0) begin
                emit   = 1'b1;
                status = ST_MISSING;
            end else begin
                phase_next = PH_ENTRIES;
            end
        end else if (accept && phase_reg == PH_ENTRIES) begin
            case (pos_reg) inside
                POS_TYPE:                     etype_next = din;
                POS_ID:                       eid_next   = din;
                POS_OFS0, POS_OFS1, POS_OFS2: eofs_next  = {eofs_reg[PlaceW-ByteW-1:0], din};
                default:                      esize_next = {esize_reg[PlaceW-ByteW-1:0], din};
            endcase

            if (pos_reg != POS_LAST) begin
                pos_next = pos_reg + 1'b1;
            end else begin
                pos_next = '0;
                if ({{(LenW-PlaceW-1){1'b0}}, end_sum} > total_reg) begin
                    emit   = 1'b1;
                    status = ST_BOUNDS;
                end else begin
                    if (etype_reg == type_code_reg) begin
                        // equal ids resolve to the binary repository
                        if (eid_reg == binary_id_reg) begin
                            bplace_next = {eofs_reg, esize_next};
                            bseen_next  = 1'b1;
                        end else if (eid_reg == string_id_reg) begin
                            splace_next = {eofs_reg, esize_next};
                            sseen_next  = 1'b1;
                        end
                    end
                    left_next = left_reg - 1'b1;
                    if (left_reg == {{(ByteW-1){1'b0}}, 1'b1}) begin
                        emit   = 1'b1;
                        status = (bseen_next && sseen_next) ? ST_OK : ST_MISSING;
                    end
                end
            end
        end

        if (emit) begin
            phase_next = PH_DONE;
        end

        // places reported only for ok / missing
        places      = (status == ST_OK) || (status == ST_MISSING);
        m_data_next = '0;
        m_data_next[StatusW-1:0] = status;
        if (places && bseen_next) begin
            m_data_next[StatusW +: 2*PlaceW] = {bplace_next[PlaceW-1:0],
                                                bplace_next[2*PlaceW-1:PlaceW]};
        end
        if (places && sseen_next) begin
            m_data_next[StatusW+2*PlaceW +: 2*PlaceW] = {splace_next[PlaceW-1:0],
                                                         splace_next[2*PlaceW-1:PlaceW]};
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_code_reg <= '0;
            binary_id_reg <= '0;
            string_id_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TYPE_CODE: type_code_reg <= cfg_wr_data;
                CFG_BINARY_ID: binary_id_reg <= cfg_wr_data;
                CFG_STRING_ID: string_id_reg <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            left_reg    <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            bseen_reg   <= 1'b0;
            sseen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            bseen_reg <= bseen_next;
            sseen_reg <= sseen_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        etype_reg  <= etype_next;
        eid_reg    <= eid_next;
        eofs_reg   <= eofs_next;
        esize_reg  <= esize_next;
        bplace_reg <= bplace_next;
        splace_reg <= splace_next;
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Container header parser testbench
// Streams container headers into the parser: a handful of directed corner
// cases, then random containers under four register settings. A local
// model predicts each report word, and the monitor compares every field.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb
    import chp_pkg::*;
();

    // one input word as the sender sees it
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             start;
        logic [LenW-1:0]  clen;
    } hdr_word_t;

    // one report word, field by field
    typedef struct packed {
        status_t            status;
        logic [PlaceW-1:0]  bin_ofs;
        logic [PlaceW-1:0]  bin_len;
        logic [PlaceW-1:0]  str_ofs;
        logic [PlaceW-1:0]  str_len;
    } place_report_t;

    localparam int unsigned MaxPlace   = 24'hFFFFFF;
    localparam longint      MaxSpan    = 64'h1FFFFFE;   // largest offset + length
    localparam int          PhaseWords = 420;
    localparam int          LongHold   = 300;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CfgAddrW-1:0]  cfg_addr    = CFG_TYPE_CODE;
    logic [ByteW-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [SDataW-1:0]    s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [MDataW-1:0]    m_tdata;

    container_header_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Local copy of the register file and of the parser state
    // ------------------------------------------------------------------
    logic [ByteW-1:0]     type_code = 8'd0;
    logic [ByteW-1:0]     bin_id    = 8'd0;
    logic [ByteW-1:0]     str_id    = 8'd1;

    phase_t               prs_phase = PH_IDLE;
    logic [7:0]           prs_left  = '0;
    logic [EntryIdxW-1:0] prs_pos   = '0;
    logic [LenW-1:0]      prs_total = '0;
    logic [7:0]           ent_type  = '0;
    logic [7:0]           ent_id    = '0;
    logic [PlaceW-1:0]    ent_ofs   = '0;
    logic [PlaceW-1:0]    ent_len   = '0;
    logic                 bin_seen  = 1'b0;
    logic                 str_seen  = 1'b0;
    logic [2*PlaceW-1:0]  bin_place = '0;
    logic [2*PlaceW-1:0]  str_place = '0;

    hdr_word_t            pending_words[$];     // words not yet offered
    place_report_t        expected_reports[$];  // reports predicted, not yet seen
    int                   failures      = 0;
    int                   results_taken = 0;

    // Close the container: places only survive for ok / missing
    function automatic place_report_t close_container(input status_t st);
        place_report_t rep;
        logic          keep;
        keep        = (st == ST_OK) || (st == ST_MISSING);
        rep.status  = st;
        rep.bin_ofs = (keep && bin_seen) ? bin_place[2*PlaceW-1:PlaceW] : '0;
        rep.bin_len = (keep && bin_seen) ? bin_place[PlaceW-1:0]        : '0;
        rep.str_ofs = (keep && str_seen) ? str_place[2*PlaceW-1:PlaceW] : '0;
        rep.str_len = (keep && str_seen) ? str_place[PlaceW-1:0]        : '0;
        prs_phase   = PH_DONE;
        return rep;
    endfunction

    // Advance the parser by one accepted word; returns 1 with a report
    function automatic logic parse_header_byte(input hdr_word_t w,
                                               output place_report_t rep);
        rep = '0;
        if (w.start) begin
            // any start aborts the container in flight
            prs_total = w.clen;
            prs_left  = w.data;
            prs_pos   = '0;
            bin_seen  = 1'b0;
            str_seen  = 1'b0;
            if (w.clen == 0 || longint'(w.clen) < 1 + 8 * longint'(w.data)) begin
                rep = close_container(ST_SHORT);
                return 1'b1;
            end
            if (w.data == 0) begin
                rep = close_container(ST_MISSING);
                return 1'b1;
            end
            prs_phase = PH_ENTRIES;
            return 1'b0;
        end

        // stray bytes while waiting or after a report
        if (prs_phase != PH_ENTRIES)
            return 1'b0;

        case (prs_pos)
            POS_TYPE: ent_type = w.data;
            POS_ID:   ent_id   = w.data;
            POS_OFS0, POS_OFS1, POS_OFS2: ent_ofs = {ent_ofs[PlaceW-9:0], w.data};
            default:  ent_len  = {ent_len[PlaceW-9:0], w.data};
        endcase

        if (prs_pos != POS_LAST) begin
            prs_pos = prs_pos + 1'b1;
            return 1'b0;
        end
        prs_pos = '0;

        if (({9'b0, ent_ofs} + {9'b0, ent_len}) > {1'b0, prs_total}) begin
            rep = close_container(ST_BOUNDS);
            return 1'b1;
        end

        // later entries override; equal ids resolve to binary
        if (ent_type == type_code) begin
            if (ent_id == bin_id) begin
                bin_place = {ent_ofs, ent_len};
                bin_seen  = 1'b1;
            end else if (ent_id == str_id) begin
                str_place = {ent_ofs, ent_len};
                str_seen  = 1'b1;
            end
        end

        prs_left = prs_left - 1'b1;
        if (prs_left == 0) begin
            rep = close_container((bin_seen && str_seen) ? ST_OK : ST_MISSING);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(input logic [7:0] data, input logic start,
                                      input logic [31:0] clen);
        hdr_word_t w;
        w.data  = data;
        w.start = start;
        w.clen  = clen;
        pending_words.push_back(w);
    endfunction

    // entry bytes: type, id, offset and length big-endian; keep trims a
    // truncated entry
    function automatic void push_entry(input logic [7:0] ty, input logic [7:0] id,
                                       input logic [23:0] ofs, input logic [23:0] len,
                                       input int keep);
        logic [63:0] raw;
        raw = {ty, id, ofs, len};
        for (int i = 0; i < keep && i < 8; i++)
            push_word(raw[63 - 8*i -: 8], 1'b0, $urandom);
    endfunction

    // one random container; returns the number of words queued
    function automatic int push_container();
        int          kind, n, cut, made, keep;
        longint      clen, room, ofs, len, lo, hi;
        logic [7:0]  ty, id;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            push_word(8'($urandom), 1'b1, 32'd0);
            return 1;
        end
        if (kind < 14) begin
            // header does not fit
            n = $urandom_range(1, 255);
            push_word(8'(n), 1'b1, $urandom_range(0, 8 * n));
            return 1;
        end
        if (kind < 18) begin
            push_word(8'd0, 1'b1, $urandom_range(1, 32'hFFFFFFFF));
            return 1;
        end

        n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
            0:       clen = longint'(1 + 8 * n);
            1:       clen = longint'($urandom_range(1 + 8 * n, 4096));
            2:       clen = 64'hFFFFFFFF;
            default: clen = longint'($urandom_range(1 + 8 * n, 32'hFFFFFFFF));
        endcase
        // now and then a restart cuts the container short
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8 * n - 1) : 8 * n;
        push_word(8'(n), 1'b1, 32'(clen));
        made = 1;
        room = (clen > MaxSpan) ? MaxSpan : clen;

        for (int i = 0; i < n; i++) begin
            keep = cut - 8 * i;
            if (keep <= 0)
                break;
            ty = ($urandom_range(0, 3) != 0) ? type_code : 8'($urandom);
            case ($urandom_range(0, 4))
                0, 1:    id = bin_id;
                2, 3:    id = str_id;
                default: id = 8'($urandom);
            endcase
            if (room < MaxSpan && $urandom_range(0, 24) == 0) begin
                // entry runs past the end of the container
                ofs = (clen >= MaxPlace) ? longint'(MaxPlace)
                                         : longint'($urandom_range(0, 32'(clen)));
                lo  = clen + 1 - ofs;
                len = longint'($urandom_range(32'(lo), MaxPlace));
            end else begin
                ofs = longint'($urandom_range(0, 32'((room > MaxPlace) ? MaxPlace : room)));
                hi  = ((room - ofs) > MaxPlace) ? MaxPlace : (room - ofs);
                len = ($urandom_range(0, 5) == 0) ? hi : longint'($urandom_range(0, 32'(hi)));
            end
            push_entry(ty, id, 24'(ofs), 24'(len), keep);
            made += (keep > 8) ? 8 : keep;
        end
        return made;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued words, random gap before each
    // ------------------------------------------------------------------
    hdr_word_t     tx_word;
    place_report_t tx_report;
    int            tx_gap  = 0;
    logic          tx_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (parse_header_byte(tx_word, tx_report))
                    expected_reports.push_back(tx_report);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0 || pending_words.size() == 0) begin
                    if (tx_gap != 0)
                        tx_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    tx_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_word.clen, tx_word.data};
                    s_tuser  <= tx_word.start;
                    // occasional switch between bursts and gappy traffic
                    if ($urandom_range(0, 49) == 0)
                        tx_calm = ~tx_calm;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 14);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each report word, stalls at random afterwards
    // ------------------------------------------------------------------
    int            rx_gap  = 0;
    logic          rx_calm = 1'b0;
    int            hold_left = 0;
    logic          hold_done = 1'b0;
    place_report_t rx_want;

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
                if (expected_reports.size() == 0) begin
                    $error("report word with none expected: %h", m_tdata);
                    failures++;
                end else begin
                    rx_want = expected_reports.pop_front();
                    check_field("status",        24'(rx_want.status), 24'(m_tdata[1:0]));
                    check_field("binary_offset", rx_want.bin_ofs, m_tdata[25:2]);
                    check_field("binary_length", rx_want.bin_len, m_tdata[49:26]);
                    check_field("string_offset", rx_want.str_ofs, m_tdata[73:50]);
                    check_field("string_length", rx_want.str_len, m_tdata[97:74]);
                end
                if ($urandom_range(0, 9) == 0)
                    rx_calm = ~rx_calm;
                rx_gap = rx_calm ? 0 : $urandom_range(0, 14);
            end else if (rx_gap != 0) begin
                rx_gap--;
            end
            m_tready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    // one long hold-off once traffic is flowing; the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_taken >= 20) begin
            hold_left <= LongHold;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic reg_write(input cfg_idx_t idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_TYPE_CODE: type_code = value;
            CFG_BINARY_ID: bin_id    = value;
            CFG_STRING_ID: str_id    = value;
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [7:0] ty, input logic [7:0] bid,
                                input logic [7:0] sid);
        reg_write(CFG_TYPE_CODE, ty);
        reg_write(CFG_BINARY_ID, bid);
        reg_write(CFG_STRING_ID, sid);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // drain both sides, then let a trailing entry byte settle
    task automatic settle();
        int spin;
        spin = 0;
        while (pending_words.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (expected_reports.size() != 0 && spin < 2000) begin
            spin++;
            @(negedge aclk);
        end
        if (expected_reports.size() != 0) begin
            $error("%0d report words never arrived", expected_reports.size());
            failures += expected_reports.size();
            expected_reports.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic fill_random(input int quota);
        int queued;
        queued = 0;
        while (queued < quota) begin
            // stray words between containers; not counted
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(1, 3)) push_word(8'($urandom), 1'b0, $urandom);
            queued += push_container();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners, reset register values (type 0, binary 0, string 1)
        push_word(8'hFF, 1'b0, 32'hFFFFFFFF);           // stray word while waiting
        push_word(8'h00, 1'b1, 32'd0);                  // empty container
        push_word(8'h00, 1'b1, 32'hFFFFFFFF);           // no entries at all
        push_word(8'hFF, 1'b1, 32'd2040);               // header one byte too long
        push_word(8'h02, 1'b1, 32'hFFFFFFFF);           // both repositories, extremes
        push_entry(8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 8);
        push_entry(8'h00, 8'h01, 24'h000000, 24'h000000, 8);
        push_word(8'h01, 1'b1, 32'h00FFFFFF);           // entry one byte past the end
        push_entry(8'h00, 8'h00, 24'h000001, 24'hFFFFFF, 8);
        push_word(8'hAA, 1'b0, 32'h00000000);           // stray word after a report
        settle();

        // random containers under several register settings
        load_setting(8'h00, 8'h00, 8'h00);              // equal ids
        fill_random(PhaseWords);
        settle();
        load_setting(8'hFF, 8'hFF, 8'h00);
        fill_random(PhaseWords);
        settle();
        load_setting(8'($urandom), 8'($urandom), 8'($urandom));
        fill_random(PhaseWords);
        settle();
        load_setting(8'h00, 8'h01, 8'hFF);
        fill_random(PhaseWords);
        settle();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
